// ----- hw/rtl/sbe_pkg.sv -----
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and codes for the stack bytecode executor.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

	typedef enum logic [4:0] {
		OPC_NOP      = 5'd0,
		OPC_PUSH     = 5'd1,
		OPC_POP      = 5'd2,
		OPC_DUP      = 5'd3,
		OPC_LOAD     = 5'd4,
		OPC_STORE    = 5'd5,
		OPC_LDGLOB   = 5'd6,
		OPC_STGLOB   = 5'd7,
		OPC_ADD      = 5'd8,
		OPC_SUB      = 5'd9,
		OPC_MUL      = 5'd10,
		OPC_DIV      = 5'd11,
		OPC_MOD      = 5'd12,
		OPC_NEG      = 5'd13,
		OPC_EQ       = 5'd14,
		OPC_NEQ      = 5'd15,
		OPC_LT       = 5'd16,
		OPC_GT       = 5'd17,
		OPC_LEQ      = 5'd18,
		OPC_GEQ      = 5'd19,
		OPC_JMP      = 5'd20,
		OPC_JZ       = 5'd21,
		OPC_JNZ      = 5'd22,
		OPC_CALL     = 5'd23,
		OPC_RET      = 5'd24,
		OPC_RETVAL   = 5'd25,
		OPC_ENTER    = 5'd26,
		OPC_PRINT    = 5'd27,
		OPC_PRINTSTR = 5'd28,
		OPC_HALT     = 5'd29
	} opcode_t;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_OVERFLOW  = 4'd1,
		ERR_UNDERFLOW = 4'd2,
		ERR_NO_FRAME  = 4'd3,
		ERR_BAD_LOCAL = 4'd4,
		ERR_DIV_ZERO  = 4'd5,
		ERR_BAD_FUNC  = 4'd6,
		ERR_CALL_OVF  = 4'd7,
		ERR_ILLEGAL   = 4'd8,
		ERR_BAD_JUMP  = 4'd9,
		ERR_NO_MAIN   = 4'd10
	} err_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_EXEC  = 1'b1;

	localparam logic [1:0] CFG_PROG_LEN   = 2'd0;
	localparam logic [1:0] CFG_MAIN_PC    = 2'd1;
	localparam logic [1:0] CFG_FUNC_COUNT = 2'd2;

	typedef struct packed {
		logic latch;
		logic rd_a;
		logic rd_b;
		logic div_start;
		logic commit;
	} sbe_cmd_t;

	typedef struct packed {
		logic div_op;
		logic div_done;
		logic out_free;
	} sbe_sts_t;

	typedef struct packed {
		logic [3:0]  error_code;
		logic [31:0] print_value;
		logic        print_is_string;
		logic        print_valid;
		logic [31:0] exit_value;
		logic        running;
		logic [15:0] next_pc;
	} sbe_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sbe_ram.sv -----
// ----------------------------------------------------------------------------
// sbe_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sbe_div.sv -----
// ----------------------------------------------------------------------------
// sbe_div
// Iterative signed divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, negq_q, negr_q;
	logic [32:0] rem_sh, diff;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			negq_q <= dividend[31] ^ divisor[31];
			negr_q <= dividend[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = negq_q ? (32'd0 - quo_q) : quo_q;
	assign remainder = negr_q ? (32'd0 - rem_q) : rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sbe_dp.sv -----
// ----------------------------------------------------------------------------
// sbe_dp
// Datapath: architectural registers, stack and frame memories, ALU,
// divider, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_dp
	import sbe_pkg::*;
#(
	parameter int STACK_DEPTH = 256,
	parameter int FRAME_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_op,
	input  wire logic [71:0] in_data,
	input  wire sbe_cmd_t    cmd,
	output sbe_sts_t         sts,
	input  wire logic        out_ready,
	output logic             out_valid,
	output sbe_res_t         res
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int FIW = $clog2(FRAME_DEPTH);
	localparam int FW  = 16 + SPW + 8;
	localparam int EW  = SPW + 9;
	localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
	localparam logic [FIW-1:0] FI_LAST = FIW'(FRAME_DEPTH - 1);

	// architectural state
	logic [SPW-1:0] sp_q;
	logic [FIW-1:0] fi_q;
	logic           fi_none_q;
	logic [15:0]    pc_q;
	logic           run_q;
	logic [31:0]    exit_q;
	logic [15:0]    plen_q;
	logic [16:0]    main_q;
	logic [7:0]     fcnt_q;
	logic           out_valid_q;
	sbe_res_t       res_q;

	// latched item
	logic        op_q;
	logic [4:0]  opc_q;
	logic [31:0] opnd_q;
	logic [15:0] centry_q;
	logic [7:0]  cpar_q, cloc_q;
	logic [31:0] top_q;
	logic        loc_ok_q;
	logic [AW-1:0] loc_addr_q;

	// memories
	logic          st_we, st_re;
	logic [AW-1:0] st_wa, st_ra;
	logic [31:0]   st_wd, st_rd;
	logic            fr_we;
	logic [FIW-1:0]  fr_wa;
	logic [FW-1:0]   fr_wd, fr_rd;

	logic [15:0]    f_ret;
	logic [SPW-1:0] f_base;
	logic [7:0]     f_par;

	assign f_ret  = fr_rd[FW-1 -: 16];
	assign f_base = fr_rd[8 +: SPW];
	assign f_par  = fr_rd[7:0];

	sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_wa),
		.wdata (st_wd),
		.re    (st_re),
		.raddr (st_ra),
		.rdata (st_rd)
	);

	sbe_ram #(.WIDTH(FW), .DEPTH(FRAME_DEPTH)) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_wa),
		.wdata (fr_wd),
		.re    (cmd.rd_a),
		.raddr (fi_q),
		.rdata (fr_rd)
	);

	logic        div_done;
	logic [31:0] div_quo, div_rem;

	sbe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (st_rd),
		.divisor   (top_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// address helpers
	logic [SPW-1:0] sp_m1, sp_m2;
	logic signed [33:0] la;
	logic la_ok, glob_ok, sp_zero, sp_full, jump_bad;

	assign sp_m1   = sp_q - SPW'(1);
	assign sp_m2   = sp_q - SPW'(2);
	assign la      = $signed({{(34-SPW){1'b0}}, f_base}) + $signed({{2{opnd_q[31]}}, opnd_q});
	assign la_ok   = !la[33] && (la < $signed(34'(STACK_DEPTH)));
	assign glob_ok = !opnd_q[31] && (opnd_q[30:0] < 31'(STACK_DEPTH));
	assign sp_zero = (sp_q == '0);
	assign sp_full = (sp_q == SP_FULL);
	assign jump_bad = opnd_q[31] || (opnd_q[30:0] > {15'd0, plen_q});

	always_comb begin
		st_re = cmd.rd_a | cmd.rd_b;
		if (cmd.rd_a) begin
			st_ra = sp_m1[AW-1:0];
		end else if (opc_q == OPC_LOAD) begin
			st_ra = la[AW-1:0];
		end else if (opc_q == OPC_LDGLOB) begin
			st_ra = opnd_q[AW-1:0];
		end else begin
			st_ra = sp_m2[AW-1:0];
		end
	end

	// ALU, operand a is the second entry read, b the top of stack
	logic [31:0] alu;
	always_comb begin
		unique case (opc_q)
			OPC_ADD: alu = st_rd + top_q;
			OPC_SUB: alu = st_rd - top_q;
			OPC_MUL: alu = st_rd * top_q;
			OPC_DIV: alu = div_quo;
			OPC_MOD: alu = div_rem;
			OPC_EQ:  alu = {31'd0, st_rd == top_q};
			OPC_NEQ: alu = {31'd0, st_rd != top_q};
			OPC_LT:  alu = {31'd0, $signed(st_rd) < $signed(top_q)};
			OPC_GT:  alu = {31'd0, $signed(st_rd) > $signed(top_q)};
			OPC_LEQ: alu = {31'd0, $signed(st_rd) <= $signed(top_q)};
			default: alu = {31'd0, $signed(st_rd) >= $signed(top_q)};
		endcase
	end

	logic [EW-1:0] call_base, call_nsp, rv_nsp;
	assign call_base = EW'(sp_q) - EW'(cpar_q);
	assign call_nsp  = call_base + EW'(cloc_q);
	assign rv_nsp    = EW'(f_base) - EW'(f_par);

	// next state
	logic [SPW-1:0] n_sp;
	logic [FIW-1:0] n_fi, fi_inc;
	logic           n_fin, n_run, pval, pstr;
	logic [15:0]    n_pc;
	logic [31:0]    n_exit, pv;
	err_t           err;

	assign fi_inc = fi_none_q ? '0 : (fi_q + FIW'(1));

	always_comb begin
		n_sp   = sp_q;
		n_fi   = fi_q;
		n_fin  = fi_none_q;
		n_pc   = pc_q;
		n_run  = run_q;
		n_exit = exit_q;
		err    = ERR_NONE;
		pval   = 1'b0;
		pstr   = 1'b0;
		pv     = '0;
		st_we  = 1'b0;
		st_wa  = sp_q[AW-1:0];
		st_wd  = top_q;
		fr_we  = 1'b0;
		fr_wa  = fi_inc;
		fr_wd  = {pc_q + 16'd1, call_base[SPW-1:0], cpar_q};
		if (op_q == OP_START) begin
			if (main_q[16]) begin
				err = ERR_NO_MAIN;
			end else begin
				n_pc  = main_q[15:0];
				n_run = 1'b1;
				n_fi  = '0;
				n_fin = 1'b0;
				fr_we = 1'b1;
				fr_wa = '0;
				fr_wd = {plen_q, {SPW{1'b0}}, 8'd0};
			end
		end else if (run_q) begin
			n_pc = pc_q + 16'd1;
			unique case (opc_q)
				OPC_NOP: begin
				end
				OPC_PUSH: begin
					if (sp_full) begin
						err = ERR_OVERFLOW;
					end else begin
						st_we = 1'b1;
						st_wd = opnd_q;
						n_sp  = sp_q + SPW'(1);
					end
				end
				OPC_POP: begin
					if (sp_zero) err = ERR_UNDERFLOW;
					else n_sp = sp_m1;
				end
				OPC_DUP: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else if (sp_full) begin
						err = ERR_OVERFLOW;
					end else begin
						st_we = 1'b1;
						n_sp  = sp_q + SPW'(1);
					end
				end
				OPC_LOAD: begin
					if (fi_none_q) begin
						err = ERR_NO_FRAME;
					end else if (!loc_ok_q) begin
						err = ERR_BAD_LOCAL;
					end else if (sp_full) begin
						err = ERR_OVERFLOW;
					end else begin
						st_we = 1'b1;
						st_wd = st_rd;
						n_sp  = sp_q + SPW'(1);
					end
				end
				OPC_STORE: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else begin
						n_sp = sp_m1;
						if (fi_none_q) begin
							err = ERR_NO_FRAME;
						end else if (!loc_ok_q) begin
							err = ERR_BAD_LOCAL;
						end else begin
							st_we = 1'b1;
							st_wa = loc_addr_q;
						end
					end
				end
				OPC_LDGLOB: begin
					if (glob_ok) begin
						if (sp_full) begin
							err = ERR_OVERFLOW;
						end else begin
							st_we = 1'b1;
							st_wd = st_rd;
							n_sp  = sp_q + SPW'(1);
						end
					end
				end
				OPC_STGLOB: begin
					if (glob_ok) begin
						if (sp_zero) begin
							err = ERR_UNDERFLOW;
						end else begin
							n_sp  = sp_m1;
							st_we = 1'b1;
							st_wa = opnd_q[AW-1:0];
						end
					end
				end
				OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD,
				OPC_EQ, OPC_NEQ, OPC_LT, OPC_GT, OPC_LEQ, OPC_GEQ: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else if (sp_q == SPW'(1)) begin
						n_sp = '0;
						err  = ERR_UNDERFLOW;
					end else if ((opc_q == OPC_DIV || opc_q == OPC_MOD) && top_q == '0) begin
						n_sp = sp_m2;
						err  = ERR_DIV_ZERO;
					end else begin
						n_sp  = sp_m1;
						st_we = 1'b1;
						st_wa = sp_m2[AW-1:0];
						st_wd = alu;
					end
				end
				OPC_NEG: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else begin
						st_we = 1'b1;
						st_wa = sp_m1[AW-1:0];
						st_wd = 32'd0 - top_q;
					end
				end
				OPC_JMP: begin
					if (jump_bad) err = ERR_BAD_JUMP;
					else n_pc = opnd_q[15:0];
				end
				OPC_JZ, OPC_JNZ: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else begin
						n_sp = sp_m1;
						if ((top_q == '0) == (opc_q == OPC_JZ)) begin
							if (jump_bad) err = ERR_BAD_JUMP;
							else n_pc = opnd_q[15:0];
						end
					end
				end
				OPC_CALL: begin
					if (opnd_q[31] || opnd_q[30:0] >= {23'd0, fcnt_q}) begin
						err = ERR_BAD_FUNC;
					end else if (!fi_none_q && fi_q == FI_LAST) begin
						err = ERR_CALL_OVF;
					end else if (EW'(sp_q) < EW'(cpar_q)) begin
						err = ERR_BAD_JUMP;
					end else if (call_nsp > EW'(STACK_DEPTH)) begin
						err = ERR_OVERFLOW;
					end else begin
						fr_we = 1'b1;
						n_fi  = fi_inc;
						n_fin = 1'b0;
						n_sp  = call_nsp[SPW-1:0];
						n_pc  = centry_q;
					end
				end
				OPC_RET: begin
					if (fi_none_q || fi_q == '0) begin
						n_run  = 1'b0;
						n_exit = '0;
					end else begin
						n_sp = f_base;
						n_pc = f_ret;
						n_fi = fi_q - FIW'(1);
					end
				end
				OPC_RETVAL: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else begin
						n_sp = sp_m1;
						if (fi_none_q || fi_q == '0) begin
							n_run  = 1'b0;
							n_exit = top_q;
						end else if (EW'(f_base) < EW'(f_par)) begin
							err = ERR_BAD_JUMP;
						end else begin
							n_pc = f_ret;
							n_fi = fi_q - FIW'(1);
							if (rv_nsp[SPW-1:0] == SP_FULL) begin
								n_sp = rv_nsp[SPW-1:0];
								err  = ERR_OVERFLOW;
							end else begin
								st_we = 1'b1;
								st_wa = rv_nsp[AW-1:0];
								n_sp  = rv_nsp[SPW-1:0] + SPW'(1);
							end
						end
					end
				end
				OPC_ENTER: begin
					if (!fi_none_q && fi_q == '0) begin
						if (opnd_q[31]) err = ERR_BAD_JUMP;
						else if (opnd_q[30:0] > 31'(STACK_DEPTH)) err = ERR_OVERFLOW;
						else n_sp = opnd_q[SPW-1:0];
					end
				end
				OPC_PRINT: begin
					if (sp_zero) begin
						err = ERR_UNDERFLOW;
					end else begin
						n_sp = sp_m1;
						pval = 1'b1;
						pv   = top_q;
					end
				end
				OPC_PRINTSTR: begin
					pval = 1'b1;
					pstr = 1'b1;
				end
				OPC_HALT: begin
					n_run = 1'b0;
					if (!sp_zero) n_exit = top_q;
				end
				default: err = ERR_ILLEGAL;
			endcase
		end
		if (err != ERR_NONE) begin
			n_run  = 1'b0;
			n_exit = '1;
		end
		if (n_run && n_pc >= plen_q) n_run = 1'b0;
		if (!cmd.commit) begin
			st_we = 1'b0;
			fr_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			fi_q        <= '0;
			fi_none_q   <= 1'b1;
			pc_q        <= '0;
			run_q       <= 1'b0;
			exit_q      <= '0;
			plen_q      <= '0;
			main_q      <= '1;
			fcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PROG_LEN:   plen_q <= cfg_data[15:0];
					CFG_MAIN_PC:    main_q <= cfg_data[16:0];
					CFG_FUNC_COUNT: fcnt_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				sp_q        <= n_sp;
				fi_q        <= n_fi;
				fi_none_q   <= n_fin;
				pc_q        <= n_pc;
				run_q       <= n_run;
				exit_q      <= n_exit;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= in_op;
			opc_q    <= in_data[4:0];
			opnd_q   <= in_data[36:5];
			centry_q <= in_data[52:37];
			cpar_q   <= in_data[60:53];
			cloc_q   <= in_data[68:61];
		end
		if (cmd.rd_b) begin
			top_q      <= st_rd;
			loc_ok_q   <= la_ok;
			loc_addr_q <= la[AW-1:0];
		end
		if (cmd.commit) begin
			res_q.next_pc         <= n_pc;
			res_q.running         <= n_run;
			res_q.exit_value      <= n_exit;
			res_q.print_valid     <= pval;
			res_q.print_is_string <= pstr;
			res_q.print_value     <= pv;
			res_q.error_code      <= err;
		end
	end

	assign sts.div_op   = (op_q == OP_EXEC) && run_q && (opc_q == OPC_DIV || opc_q == OPC_MOD);
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign res          = res_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_FULL) else $error("stack pointer beyond depth");

	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.error_code != ERR_NONE |-> !res_q.running && res_q.exit_value == '1)
		else $error("fault left block running");

	a_run_frame: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !fi_none_q) else $error("running without a frame");

endmodule

`default_nettype wire

// ----- hw/rtl/sbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbe_ctrl
// Sequencer: operand reads, optional division wait, commit into the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ctrl
	import sbe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire sbe_sts_t sts,
	output sbe_cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_RDB  = 6'b000100,
		S_DIVS = 6'b001000,
		S_DIVW = 6'b010000,
		S_EXEC = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) state_d = S_RDA;
			end
			S_RDA: begin
				cmd.rd_a = 1'b1;
				state_d  = S_RDB;
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = sts.div_op ? S_DIVS : S_EXEC;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == S_RDA) else $error("beat taken outside idle");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free) else $error("result overwritten");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DIVW) else $error("divider not awaited");

endmodule

`default_nettype wire

// ----- hw/rtl/stack_bytecode_executor_unit.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_executor_unit
// Stack machine executing one bytecode instruction per input beat.
//
// Input beat: s_tuser 0 starts at main, 1 executes the instruction in
// s_tdata (fetched by the caller at the last reported next_pc, with the
// callee table entry for a call). Every input beat gives one output beat
// holding next_pc, run flag, exit code, print data and error code.
// Configuration beats (program length, main entry, function count) are
// taken on cfg_* at any time but are meant for idle periods.
// m_tvalid rises once the item has passed the two registered reads of
// the stack memory (states RDA and RDB) and the execute state; div and
// mod also wait in the bit-serial divider. One item in flight, so a new
// input beat is taken only after the previous one has committed.
// An input beat is taken while the previous output beat is still waiting;
// a stalled receiver holds the next result in execution until the output
// register frees. Reset clears the stack pointer, PC, run flag, exit code
// and configuration; stack and frame memories keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_bytecode_executor_unit
	import sbe_pkg::*;
#(
	parameter int STACK_DEPTH = 256,
	parameter int FRAME_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[4:0] operand[36:5] callee_entry_pc[52:37]
	// callee_param_count[60:53] callee_local_count[68:61]
	input  wire logic [71:0] s_tdata,
	// op
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// next_pc[15:0] running[16] exit_value[48:17] print_valid[49]
	// print_value[81:50] error_code[85:82]
	output logic [87:0]      m_tdata,
	// print_is_string
	output logic             m_tuser
);

	sbe_cmd_t cmd;
	sbe_sts_t sts;
	sbe_res_t res;

	sbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbe_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.res       (res)
	);

	assign cfg_ready = 1'b1;
	assign m_tuser   = res.print_is_string;
	assign m_tdata   = {2'b00, res.error_code, res.print_value, res.print_valid,
		res.exit_value, res.running, res.next_pc};

endmodule

`default_nettype wire
